// File: rtl/ppr_pkg.sv
package ppr_pkg;

	localparam int COORD_BITS  = 16;
	localparam int MAX_POINTS  = 64;
	localparam int STACK_DEPTH = 64;

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = IDX_W + 1;
	localparam int SPA_W  = $clog2(STACK_DEPTH);
	localparam int SP_W   = SPA_W + 1;
	localparam int SEG_W  = 2 * IDX_W;
	localparam int PT_W   = 2 * COORD_BITS;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int MUL_W  = DIFF_W + 1;
	localparam int CMAX_W = 2 * COORD_BITS + 1;
	localparam int LHS_W  = 2 * CMAX_W;
	localparam int T2_W   = 2 * COORD_BITS;
	localparam int C2_W   = 2 * COORD_BITS + 1;
	localparam int ACC_W  = 4 * COORD_BITS + 8;

	typedef enum logic [2:0] {
		SH_0,
		SH_C,
		SH_D,
		SH_D1,
		SH_CD,
		SH_DD
	} shift_t;

	typedef struct packed {
		logic                    en;
		logic                    clear;
		logic                    sub;
		shift_t                  shift;
		logic signed [MUL_W-1:0] a;
		logic signed [MUL_W-1:0] b;
	} mac_ctrl_t;

	typedef struct packed {
		logic            loading;
		logic [SP_W-1:0] depth;
	} seq_status_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_START,
		ST_POP,
		ST_POPW,
		ST_RDB,
		ST_CHORD,
		ST_SCAN,
		ST_PT,
		ST_M1,
		ST_M2,
		ST_CMP,
		ST_LHH,
		ST_LHL,
		ST_LLL,
		ST_T2,
		ST_CXX,
		ST_CYY,
		ST_C2,
		ST_R11,
		ST_R10,
		ST_R01,
		ST_R00,
		ST_DEC,
		ST_PUSH2,
		ST_ESCAN,
		ST_EOUT,
		ST_DONE
	} state_t;

endpackage

// File: rtl/ppr_ifs.sv
interface ppr_point_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ppr_pkg::COORD_BITS-1:0] point_x;
	logic signed [ppr_pkg::COORD_BITS-1:0] point_y;
	logic                                 final_point;

	modport source(output valid, point_x, point_y, final_point, input ready);
	modport sink(input valid, point_x, point_y, final_point, output ready);
endinterface

interface ppr_kept_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [ppr_pkg::COORD_BITS-1:0] kept_x;
	logic signed [ppr_pkg::COORD_BITS-1:0] kept_y;
	logic [ppr_pkg::IDX_W-1:0]             kept_index;
	logic                                 last_kept;
	logic                                 overflow;

	modport source(output valid, kept_x, kept_y, kept_index, last_kept, overflow, input ready);
	modport sink(input valid, kept_x, kept_y, kept_index, last_kept, overflow, output ready);
endinterface

// File: rtl/polyline_point_reduction.sv
// Load: one point per cycle while the block is idle; the line is held until the final point arrives.
// Simplify: each popped segment has its chord formed and each live interior point's cross product
// taken, then the split test, all on the single shared 18x18 multiply-accumulate unit.
// Emit: kept points leave through the output register; dropped points are skipped.
// arst_n resets the sequencer, counters and tolerance (to zero) and sets all keep flags;
// point and segment memories are not cleared.
module polyline_point_reduction (
	input  logic                           clk,
	input  logic                           arst_n,
	ppr_point_if.sink                      pt,
	ppr_kept_if.source                     kept,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ppr_pkg::COORD_BITS-1:0] tolerance
);

	ppr_pkg::mac_ctrl_t               mac_ctrl;
	ppr_pkg::seq_status_t             status;
	logic signed [ppr_pkg::ACC_W-1:0] acc;

	assign cfg_ready = 1'b1;

	ppr_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.acc  (acc)
	);

	ppr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt        (pt),
		.kept      (kept),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (tolerance),
		.acc       (acc),
		.mac       (mac_ctrl),
		.status    (status)
	);

	a_no_mac_while_loading: assert property (@(posedge clk) disable iff (!arst_n)
		status.loading |-> !mac_ctrl.en)
		else $error("multiplier active while loading points");

	a_stack_empty_while_loading: assert property (@(posedge clk) disable iff (!arst_n)
		status.loading |-> status.depth == '0)
		else $error("segment stack not empty while loading");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(kept.valid && kept.ready && kept.last_kept) |=> !kept.valid)
		else $error("result follows the last kept point");

endmodule

// File: rtl/ppr_ram.sv
module ppr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/ppr_mac.sv
module ppr_mac (
	input  logic                                clk,
	input  ppr_pkg::mac_ctrl_t                  ctrl,
	output logic signed [ppr_pkg::ACC_W-1:0]    acc
);

	localparam int AW = ppr_pkg::ACC_W;

	logic signed [2*ppr_pkg::MUL_W-1:0] prod;
	logic signed [AW-1:0]               ext;
	logic signed [AW-1:0]               shifted;
	logic signed [AW-1:0]               base;
	logic signed [AW-1:0]               acc_q;

	assign acc  = acc_q;
	assign prod = ctrl.a * ctrl.b;
	assign ext  = AW'(prod);
	assign base = ctrl.clear ? '0 : acc_q;

	always_comb begin
		unique case (ctrl.shift)
			ppr_pkg::SH_0:  shifted = ext;
			ppr_pkg::SH_C:  shifted = ext <<< ppr_pkg::COORD_BITS;
			ppr_pkg::SH_D:  shifted = ext <<< ppr_pkg::DIFF_W;
			ppr_pkg::SH_D1: shifted = ext <<< (ppr_pkg::DIFF_W + 1);
			ppr_pkg::SH_CD: shifted = ext <<< (ppr_pkg::COORD_BITS + ppr_pkg::DIFF_W);
			ppr_pkg::SH_DD: shifted = ext <<< (2 * ppr_pkg::DIFF_W);
			default:        shifted = ext;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			acc_q <= ctrl.sub ? base - shifted : base + shifted;
		end
	end

endmodule

// File: rtl/ppr_seq.sv
module ppr_seq (
	input  logic                             clk,
	input  logic                             arst_n,
	ppr_point_if.sink                        pt,
	ppr_kept_if.source                       kept,
	input  logic                             cfg_valid,
	input  logic [ppr_pkg::COORD_BITS-1:0]   cfg_data,
	input  logic signed [ppr_pkg::ACC_W-1:0] acc,
	output ppr_pkg::mac_ctrl_t               mac,
	output ppr_pkg::seq_status_t             status
);

	localparam int CB  = ppr_pkg::COORD_BITS;
	localparam int IW  = ppr_pkg::IDX_W;
	localparam int CW  = ppr_pkg::CNT_W;
	localparam int SW  = ppr_pkg::SP_W;
	localparam int SAW = ppr_pkg::SPA_W;
	localparam int DW  = ppr_pkg::DIFF_W;
	localparam int MW  = ppr_pkg::MUL_W;
	localparam int XW  = ppr_pkg::CMAX_W;
	localparam int LW  = ppr_pkg::LHS_W;
	localparam int AW  = ppr_pkg::ACC_W;

	ppr_pkg::state_t state_q, state_d;

	logic [CB-1:0]                tol_q;
	logic [ppr_pkg::MAX_POINTS-1:0] keep_q;
	logic [CW-1:0]                cnt_q;
	logic [SW-1:0]                sp_q;
	logic                         ovf_q;
	logic                         out_valid_q;

	logic [IW-1:0]                b_q, e_q, best_q;
	logic [CW-1:0]                i_q;
	logic signed [CB-1:0]         xe_q, ye_q, xb_q, yb_q;
	logic signed [DW-1:0]         dx_q, dy_q, px_q, py_q;
	logic [XW-1:0]                cmax_q;
	logic [LW-1:0]                lhs_q;
	logic [ppr_pkg::T2_W-1:0]     t2_q;
	logic [ppr_pkg::C2_W-1:0]     c2_q;
	logic signed [CB-1:0]         out_x_q, out_y_q;
	logic [IW-1:0]                out_idx_q;
	logic                         out_last_q, out_ovf_q;

	logic                         pt_wr_en, pt_rd_en;
	logic [IW-1:0]                pt_wr_addr, pt_rd_addr;
	logic [ppr_pkg::PT_W-1:0]     pt_rd_data;
	logic                         stk_wr_en, stk_rd_en;
	logic [SAW-1:0]               stk_wr_addr, stk_rd_addr;
	logic [ppr_pkg::SEG_W-1:0]    stk_wr_data, stk_rd_data;

	logic                         in_acc, out_acc, out_free, cur_keep;
	logic                         split, push_hi, push_lo, sp_room;
	logic signed [AW-1:0]         acc_abs;
	logic [XW-1:0]                mag;
	logic signed [CB-1:0]         rd_x, rd_y;

	assign in_acc   = pt.valid && pt.ready;
	assign out_acc  = kept.valid && kept.ready;
	assign out_free = !out_valid_q || kept.ready;
	assign cur_keep = keep_q[i_q[IW-1:0]];
	assign rd_x     = pt_rd_data[2*CB-1:CB];
	assign rd_y     = pt_rd_data[CB-1:0];
	assign split    = {1'b0, lhs_q} > acc[LW:0];
	assign push_hi  = CW'(e_q) >= CW'(best_q) + CW'(2);
	assign push_lo  = CW'(best_q) >= CW'(b_q) + CW'(2);
	assign sp_room  = sp_q < SW'(ppr_pkg::STACK_DEPTH);
	assign acc_abs  = acc[AW-1] ? -acc : acc;
	assign mag      = acc_abs[XW-1:0];

	assign pt.ready        = (state_q == ppr_pkg::ST_IDLE);
	assign kept.valid      = out_valid_q;
	assign kept.kept_x     = out_x_q;
	assign kept.kept_y     = out_y_q;
	assign kept.kept_index = out_idx_q;
	assign kept.last_kept  = out_last_q;
	assign kept.overflow   = out_ovf_q;

	assign status.loading = (state_q == ppr_pkg::ST_IDLE);
	assign status.depth   = sp_q;

	ppr_ram #(.WIDTH(ppr_pkg::PT_W), .DEPTH(ppr_pkg::MAX_POINTS)) u_pts (
		.clk     (clk),
		.wr_en   (pt_wr_en),
		.wr_addr (pt_wr_addr),
		.wr_data ({pt.point_x, pt.point_y}),
		.rd_en   (pt_rd_en),
		.rd_addr (pt_rd_addr),
		.rd_data (pt_rd_data)
	);

	ppr_ram #(.WIDTH(ppr_pkg::SEG_W), .DEPTH(ppr_pkg::STACK_DEPTH)) u_stack (
		.clk     (clk),
		.wr_en   (stk_wr_en),
		.wr_addr (stk_wr_addr),
		.wr_data (stk_wr_data),
		.rd_en   (stk_rd_en),
		.rd_addr (stk_rd_addr),
		.rd_data (stk_rd_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppr_pkg::ST_IDLE:  if (in_acc && pt.final_point) state_d = ppr_pkg::ST_START;
			ppr_pkg::ST_START: state_d = (cnt_q >= CW'(3)) ? ppr_pkg::ST_POP : ppr_pkg::ST_ESCAN;
			ppr_pkg::ST_POP:   state_d = (sp_q == '0) ? ppr_pkg::ST_ESCAN : ppr_pkg::ST_POPW;
			ppr_pkg::ST_POPW:  state_d = ppr_pkg::ST_RDB;
			ppr_pkg::ST_RDB:   state_d = ppr_pkg::ST_CHORD;
			ppr_pkg::ST_CHORD: state_d = ppr_pkg::ST_SCAN;
			ppr_pkg::ST_SCAN: begin
				if (i_q >= CW'(e_q)) state_d = ppr_pkg::ST_LHH;
				else if (cur_keep) state_d = ppr_pkg::ST_PT;
			end
			ppr_pkg::ST_PT:    state_d = ppr_pkg::ST_M1;
			ppr_pkg::ST_M1:    state_d = ppr_pkg::ST_M2;
			ppr_pkg::ST_M2:    state_d = ppr_pkg::ST_CMP;
			ppr_pkg::ST_CMP:   state_d = ppr_pkg::ST_SCAN;
			ppr_pkg::ST_LHH:   state_d = ppr_pkg::ST_LHL;
			ppr_pkg::ST_LHL:   state_d = ppr_pkg::ST_LLL;
			ppr_pkg::ST_LLL:   state_d = ppr_pkg::ST_T2;
			ppr_pkg::ST_T2:    state_d = ppr_pkg::ST_CXX;
			ppr_pkg::ST_CXX:   state_d = ppr_pkg::ST_CYY;
			ppr_pkg::ST_CYY:   state_d = ppr_pkg::ST_C2;
			ppr_pkg::ST_C2:    state_d = ppr_pkg::ST_R11;
			ppr_pkg::ST_R11:   state_d = ppr_pkg::ST_R10;
			ppr_pkg::ST_R10:   state_d = ppr_pkg::ST_R01;
			ppr_pkg::ST_R01:   state_d = ppr_pkg::ST_R00;
			ppr_pkg::ST_R00:   state_d = ppr_pkg::ST_DEC;
			ppr_pkg::ST_DEC:   state_d = split ? ppr_pkg::ST_PUSH2 : ppr_pkg::ST_POP;
			ppr_pkg::ST_PUSH2: state_d = ppr_pkg::ST_POP;
			ppr_pkg::ST_ESCAN: begin
				if (i_q >= cnt_q) state_d = ppr_pkg::ST_DONE;
				else if (cur_keep && out_free) state_d = ppr_pkg::ST_EOUT;
			end
			ppr_pkg::ST_EOUT:  state_d = ppr_pkg::ST_ESCAN;
			ppr_pkg::ST_DONE:  state_d = ppr_pkg::ST_IDLE;
			default:           state_d = ppr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pt_wr_en    = 1'b0;
		pt_wr_addr  = cnt_q[IW-1:0];
		pt_rd_en    = 1'b0;
		pt_rd_addr  = i_q[IW-1:0];
		stk_wr_en   = 1'b0;
		stk_wr_addr = sp_q[SAW-1:0];
		stk_wr_data = {best_q, e_q};
		stk_rd_en   = 1'b0;
		stk_rd_addr = SAW'(sp_q - SW'(1));
		mac.en      = 1'b0;
		mac.clear   = 1'b0;
		mac.sub     = 1'b0;
		mac.shift   = ppr_pkg::SH_0;
		mac.a       = MW'(dy_q);
		mac.b       = MW'(px_q);
		unique case (state_q)
			ppr_pkg::ST_IDLE: pt_wr_en = in_acc && (cnt_q < CW'(ppr_pkg::MAX_POINTS));
			ppr_pkg::ST_START: begin
				stk_wr_en   = cnt_q >= CW'(3);
				stk_wr_addr = '0;
				stk_wr_data = {IW'(0), IW'(cnt_q - CW'(1))};
			end
			ppr_pkg::ST_POP: stk_rd_en = (sp_q != '0);
			ppr_pkg::ST_POPW: begin
				pt_rd_en   = 1'b1;
				pt_rd_addr = stk_rd_data[IW-1:0];
			end
			ppr_pkg::ST_RDB: begin
				pt_rd_en   = 1'b1;
				pt_rd_addr = b_q;
			end
			ppr_pkg::ST_SCAN: pt_rd_en = 1'b1;
			ppr_pkg::ST_M1: begin
				mac.en    = 1'b1;
				mac.clear = 1'b1;
			end
			ppr_pkg::ST_M2: begin
				mac.en  = 1'b1;
				mac.sub = 1'b1;
				mac.a   = MW'(dx_q);
				mac.b   = MW'(py_q);
			end
			ppr_pkg::ST_LHH: begin
				mac.en    = 1'b1;
				mac.clear = 1'b1;
				mac.shift = ppr_pkg::SH_DD;
				mac.a     = MW'(cmax_q[XW-1:DW]);
				mac.b     = MW'(cmax_q[XW-1:DW]);
			end
			ppr_pkg::ST_LHL: begin
				mac.en    = 1'b1;
				mac.shift = ppr_pkg::SH_D1;
				mac.a     = MW'(cmax_q[XW-1:DW]);
				mac.b     = MW'(cmax_q[DW-1:0]);
			end
			ppr_pkg::ST_LLL: begin
				mac.en = 1'b1;
				mac.a  = MW'(cmax_q[DW-1:0]);
				mac.b  = MW'(cmax_q[DW-1:0]);
			end
			ppr_pkg::ST_T2: begin
				mac.en    = 1'b1;
				mac.clear = 1'b1;
				mac.a     = MW'(tol_q);
				mac.b     = MW'(tol_q);
			end
			ppr_pkg::ST_CXX: begin
				mac.en    = 1'b1;
				mac.clear = 1'b1;
				mac.a     = MW'(dx_q);
				mac.b     = MW'(dx_q);
			end
			ppr_pkg::ST_CYY: begin
				mac.en = 1'b1;
				mac.a  = MW'(dy_q);
				mac.b  = MW'(dy_q);
			end
			ppr_pkg::ST_R11: begin
				mac.en    = 1'b1;
				mac.clear = 1'b1;
				mac.shift = ppr_pkg::SH_CD;
				mac.a     = MW'(t2_q[2*CB-1:CB]);
				mac.b     = MW'(c2_q[ppr_pkg::C2_W-1:DW]);
			end
			ppr_pkg::ST_R10: begin
				mac.en    = 1'b1;
				mac.shift = ppr_pkg::SH_C;
				mac.a     = MW'(t2_q[2*CB-1:CB]);
				mac.b     = MW'(c2_q[DW-1:0]);
			end
			ppr_pkg::ST_R01: begin
				mac.en    = 1'b1;
				mac.shift = ppr_pkg::SH_D;
				mac.a     = MW'(t2_q[CB-1:0]);
				mac.b     = MW'(c2_q[ppr_pkg::C2_W-1:DW]);
			end
			ppr_pkg::ST_R00: begin
				mac.en = 1'b1;
				mac.a  = MW'(t2_q[CB-1:0]);
				mac.b  = MW'(c2_q[DW-1:0]);
			end
			ppr_pkg::ST_DEC: stk_wr_en = split && push_hi && sp_room;
			ppr_pkg::ST_PUSH2: begin
				stk_wr_en   = push_lo && sp_room;
				stk_wr_data = {b_q, best_q};
			end
			ppr_pkg::ST_ESCAN: pt_rd_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppr_pkg::ST_IDLE;
			tol_q       <= '0;
			keep_q      <= '1;
			cnt_q       <= '0;
			sp_q        <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				tol_q <= cfg_data;
			end
			if (state_q == ppr_pkg::ST_EOUT) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ppr_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (cnt_q < CW'(ppr_pkg::MAX_POINTS)) cnt_q <= cnt_q + CW'(1);
						else ovf_q <= 1'b1;
					end
				end
				ppr_pkg::ST_START: sp_q <= (cnt_q >= CW'(3)) ? SW'(1) : '0;
				ppr_pkg::ST_POP:   if (sp_q != '0) sp_q <= sp_q - SW'(1);
				ppr_pkg::ST_DEC: begin
					if (split) begin
						if (push_hi && sp_room) sp_q <= sp_q + SW'(1);
					end else begin
						// drop the interior of the segment
						for (int j = 0; j < ppr_pkg::MAX_POINTS; j++) begin
							if (CW'(j) > CW'(b_q) && CW'(j) < CW'(e_q)) keep_q[j] <= 1'b0;
						end
					end
				end
				ppr_pkg::ST_PUSH2: if (push_lo && sp_room) sp_q <= sp_q + SW'(1);
				ppr_pkg::ST_DONE: begin
					keep_q <= '1;
					cnt_q  <= '0;
					sp_q   <= '0;
					ovf_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ppr_pkg::ST_START: i_q <= '0;
			ppr_pkg::ST_POP:   i_q <= '0;
			ppr_pkg::ST_POPW: begin
				b_q <= stk_rd_data[2*IW-1:IW];
				e_q <= stk_rd_data[IW-1:0];
			end
			ppr_pkg::ST_RDB: begin
				xe_q <= rd_x;
				ye_q <= rd_y;
			end
			ppr_pkg::ST_CHORD: begin
				xb_q   <= rd_x;
				yb_q   <= rd_y;
				dx_q   <= DW'(xe_q) - DW'(rd_x);
				dy_q   <= DW'(ye_q) - DW'(rd_y);
				i_q    <= CW'(b_q) + CW'(1);
				cmax_q <= '0;
				best_q <= b_q;
			end
			ppr_pkg::ST_SCAN: if (i_q < CW'(e_q) && !cur_keep) i_q <= i_q + CW'(1);
			ppr_pkg::ST_PT: begin
				px_q <= DW'(rd_x) - DW'(xb_q);
				py_q <= DW'(rd_y) - DW'(yb_q);
			end
			ppr_pkg::ST_CMP: begin
				// first point wins a tie
				if (mag > cmax_q) begin
					cmax_q <= mag;
					best_q <= i_q[IW-1:0];
				end
				i_q <= i_q + CW'(1);
			end
			ppr_pkg::ST_T2:  lhs_q <= acc[LW-1:0];
			ppr_pkg::ST_CXX: t2_q  <= acc[ppr_pkg::T2_W-1:0];
			ppr_pkg::ST_C2:  c2_q  <= acc[ppr_pkg::C2_W-1:0];
			ppr_pkg::ST_ESCAN: if (i_q < cnt_q && !cur_keep) i_q <= i_q + CW'(1);
			ppr_pkg::ST_EOUT: begin
				out_x_q    <= rd_x;
				out_y_q    <= rd_y;
				out_idx_q  <= i_q[IW-1:0];
				out_last_q <= (i_q == cnt_q - CW'(1));
				out_ovf_q  <= ovf_q;
				i_q        <= i_q + CW'(1);
			end
			default: ;
		endcase
	end

endmodule

// File: dv/ppr_line_checker.sv
`timescale 1ns / 1ps

module ppr_line_checker (
	input  logic clk,
	input  logic arst_n,
	ppr_point_if pt,
	ppr_kept_if  kept,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [ppr_pkg::COORD_BITS-1:0] tolerance,
	output int   errors,
	output int   pending,
	output int   kept_seen
);
	import ppr_pkg::*;

	typedef struct {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [IDX_W-1:0]             idx;
		logic                         last;
		logic                         ovf;
	} kept_point_t;

	kept_point_t kept_q[$];

	logic [COORD_BITS-1:0]        eps;
	logic signed [COORD_BITS-1:0] line_x[MAX_POINTS];
	logic signed [COORD_BITS-1:0] line_y[MAX_POINTS];
	bit                           keep[MAX_POINTS];
	int                           n_pts;
	bit                           dropped;

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		errors++;
	endtask

	// Douglas-Peucker with an explicit segment stack, then queue the kept points.
	task automatic reduce_line();
		int                seg_b[$];
		int                seg_e[$];
		int                b, e, best, last;
		longint            dx, dy, px, py, c, chord;
		longint unsigned   mag, peak, eps2;
		logic [127:0]      lhs, rhs;
		kept_point_t       kp;
		eps2 = longint'(eps) * longint'(eps);
		if (n_pts >= 3) begin
			seg_b = {seg_b, 0};
			seg_e = {seg_e, n_pts - 1};
		end
		while (seg_b.size() > 0) begin
			b = seg_b.pop_back();
			e = seg_e.pop_back();
			dx = longint'(line_x[e]) - longint'(line_x[b]);
			dy = longint'(line_y[e]) - longint'(line_y[b]);
			peak = 0;
			best = 0;
			for (int i = b + 1; i < e; i++) begin
				if (!keep[i])
					continue;
				px = longint'(line_x[i]) - longint'(line_x[b]);
				py = longint'(line_y[i]) - longint'(line_y[b]);
				c = dy * px - dx * py;
				mag = (c < 0) ? longint'(-c) : c;
				if (mag > peak) begin
					peak = mag;
					best = i;
				end
			end
			chord = dx * dx + dy * dy;
			lhs = {64'd0, peak} * {64'd0, peak};
			rhs = {64'd0, eps2} * {64'd0, chord};
			if (lhs > rhs) begin
				if (e >= best + 2) begin
					seg_b = {seg_b, best};
					seg_e = {seg_e, e};
				end
				if (best >= b + 2) begin
					seg_b = {seg_b, b};
					seg_e = {seg_e, best};
				end
			end else begin
				for (int i = b + 1; i < e; i++)
					keep[i] = 0;
			end
		end
		last = 0;
		for (int i = 0; i < n_pts; i++)
			if (keep[i])
				last = i;
		for (int i = 0; i < n_pts; i++) begin
			if (!keep[i])
				continue;
			kp.x    = line_x[i];
			kp.y    = line_y[i];
			kp.idx  = i[IDX_W-1:0];
			kp.last = (i == last);
			kp.ovf  = dropped;
			kept_q = {kept_q, kp};
		end
		for (int i = 0; i < MAX_POINTS; i++)
			keep[i] = 1;
		n_pts = 0;
		dropped = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		kept_point_t want;
		if (!arst_n) begin
			eps = '0;
			n_pts = 0;
			dropped = 0;
			for (int i = 0; i < MAX_POINTS; i++)
				keep[i] = 1;
			kept_q.delete();
			errors = 0;
			pending = 0;
			kept_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				eps = tolerance;
			if (kept.valid && kept.ready) begin
				kept_seen++;
				if (kept_q.size() == 0) begin
					report_mismatch($sformatf("unexpected kept point idx %0d", kept.kept_index));
				end else begin
					want = kept_q.pop_front();
					if (kept.kept_x !== want.x)
						report_mismatch($sformatf("kept_x %0d, want %0d (idx %0d)",
							kept.kept_x, want.x, want.idx));
					if (kept.kept_y !== want.y)
						report_mismatch($sformatf("kept_y %0d, want %0d (idx %0d)",
							kept.kept_y, want.y, want.idx));
					if (kept.kept_index !== want.idx)
						report_mismatch($sformatf("kept_index %0d, want %0d",
							kept.kept_index, want.idx));
					if (kept.last_kept !== want.last)
						report_mismatch($sformatf("last_kept %b, want %b (idx %0d)",
							kept.last_kept, want.last, want.idx));
					if (kept.overflow !== want.ovf)
						report_mismatch($sformatf("overflow %b, want %b (idx %0d)",
							kept.overflow, want.ovf, want.idx));
				end
			end
			if (pt.valid && pt.ready) begin
				if (n_pts < MAX_POINTS) begin
					line_x[n_pts] = pt.point_x;
					line_y[n_pts] = pt.point_y;
					n_pts++;
				end else begin
					dropped = 1;
				end
				if (pt.final_point)
					reduce_line();
			end
			pending = kept_q.size();
		end
	end

endmodule

// File: dv/polyline_point_reduction_test.sv
`timescale 1ns / 1ps

module polyline_point_reduction_test;
	import ppr_pkg::*;

	localparam int IDLE_PCT   = 38;
	localparam int STALL_SPAN = 400;
	localparam int WATCH_MAX  = 200000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [COORD_BITS-1:0] tolerance;
	int                    errors, pending, kept_seen;
	int                    points_sent, lines_sent;
	bit                    steady;
	bit                    hold_req;

	ppr_point_if pt_bus();
	ppr_kept_if  kept_bus();

	polyline_point_reduction uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt       (pt_bus),
		.kept     (kept_bus),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.tolerance(tolerance)
	);

	ppr_line_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt       (pt_bus),
		.kept     (kept_bus),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.tolerance(tolerance),
		.errors   (errors),
		.pending  (pending),
		.kept_seen(kept_seen)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Receiver: random backpressure, plus one long hold-off on request.
	initial begin
		kept_bus.ready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				kept_bus.ready = 0;
				repeat (STALL_SPAN) @(negedge clk);
			end
			kept_bus.ready = steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: count cycles with no transaction anywhere.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((pt_bus.valid && pt_bus.ready) || (kept_bus.valid && kept_bus.ready) ||
			    (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCH_MAX) begin
				$display("watchdog expired after %0d idle cycles", quiet);
				$display("polyline_point_reduction_test: errors");
				$finish;
			end
		end
	end

	task automatic write_tolerance(input logic [COORD_BITS-1:0] value);
		@(negedge clk);
		cfg_valid = 1;
		tolerance = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// Hold until every kept point is out, then let the block settle.
	task automatic drain();
		@(negedge clk);
		pt_bus.valid = 0;
		wait (pending == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic send_point(input int x, input int y, input bit fin);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			pt_bus.valid = 0;
			@(negedge clk);
		end
		pt_bus.valid       = 1;
		pt_bus.point_x     = x[COORD_BITS-1:0];
		pt_bus.point_y     = y[COORD_BITS-1:0];
		pt_bus.final_point = fin;
		do @(posedge clk); while (!pt_bus.ready);
		points_sent++;
		if (fin)
			lines_sent++;
	endtask

	// Full-range points, or a random walk that gives curves worth simplifying.
	task automatic send_line(input int n, input bit walk, input int step);
		int x, y;
		x = $urandom_range(40000) - 20000;
		y = $urandom_range(40000) - 20000;
		for (int i = 0; i < n; i++) begin
			if (walk) begin
				x += $urandom_range(2 * step) - step;
				y += $urandom_range(2 * step) - step;
				send_point(x, y, i == n - 1);
			end else begin
				send_point($signed(16'($urandom)), $signed(16'($urandom)), i == n - 1);
			end
		end
		@(negedge clk);
		pt_bus.valid = 0;
	endtask

	initial begin
		int n;
		arst_n = 0;
		cfg_valid = 0;
		tolerance = '0;
		pt_bus.valid = 0;
		pt_bus.point_x = '0;
		pt_bus.point_y = '0;
		pt_bus.final_point = 0;
		steady = 0;
		hold_req = 0;
		points_sent = 0;
		lines_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		write_tolerance(16'd0);
		send_point(32767, -32768, 1);
		send_point(-32768, 32767, 0);
		send_point(32767, -32768, 1);
		// coincident endpoints: interior must go
		send_point(5, 5, 0);
		send_point(100, -300, 0);
		send_point(5, 5, 1);
		// collinear interior
		send_point(0, 0, 0);
		send_point(1, 1, 0);
		send_point(2, 2, 0);
		send_point(3, 3, 1);
		// zigzag at the extremes, then a tie between two interior points
		send_point(-32768, -32768, 0);
		send_point(32767, -32768, 0);
		send_point(-32768, 32767, 0);
		send_point(32767, 32767, 1);
		send_point(0, 0, 0);
		send_point(1, 5, 0);
		send_point(2, 5, 0);
		send_point(3, 0, 1);
		drain();
		write_tolerance(16'hFFFF);
		send_point(-32768, -32768, 0);
		send_point(0, 32767, 0);
		send_point(32767, -32768, 1);
		drain();

		write_tolerance(16'd3);
		steady = 1;
		send_line(12, 1, 300);
		hold_req = 1;
		send_line(20, 1, 300);
		drain();
		steady = 0;
		while (points_sent < 60) begin
			case ($urandom_range(3))
				0: write_tolerance(16'd0);
				1: write_tolerance(16'hFFFF);
				2: write_tolerance(16'($urandom_range(40)));
				default: write_tolerance(16'($urandom));
			endcase
			repeat ($urandom_range(3, 1)) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
				send_line(n, $urandom_range(4) != 0, $urandom_range(2000, 5));
			end
			drain();
		end
		// overflow: two points past capacity
		write_tolerance(16'd10);
		send_line(MAX_POINTS + 2, 1, 400);
		drain();

		$display("sent %0d points in %0d lines, checked %0d kept points",
			points_sent, lines_sent, kept_seen);
		$display("covered short, coincident, collinear, overflow lines and tolerance extremes");
		if (errors == 0)
			$display("polyline_point_reduction_test: clean");
		else
			$display("polyline_point_reduction_test: errors");
		$finish;
	end

endmodule
